// ===== sv/dttp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttp_pkg
// shared constants, codes and the command word for the task picker
// ----------------------------------------------------------------------------
package dttp_pkg;

  // default configuration
  localparam int MaxTasks   = 32;
  localparam int PrioBits   = 8;
  localparam int QueueDepth = 2;

  // fixed field widths of the ports
  localparam int OpW     = 2;
  localparam int SlotW   = 5;
  localparam int InPrioW = 8;
  localparam int StatusW = 3;
  localparam int TicksW  = 9;

  // op codes
  localparam logic [OpW-1:0] OP_CREATE  = 2'd0;
  localparam logic [OpW-1:0] OP_SET     = 2'd1;
  localparam logic [OpW-1:0] OP_REQUEUE = 2'd2;
  localparam logic [OpW-1:0] OP_PICK    = 2'd3;

  // task status codes
  localparam logic [StatusW-1:0] ST_READY   = 3'd0;
  localparam logic [StatusW-1:0] ST_RUNNING = 3'd1;
  localparam logic [StatusW-1:0] ST_BLOCKED = 3'd2;
  localparam logic [StatusW-1:0] ST_WAITING = 3'd3;
  localparam logic [StatusW-1:0] ST_HANGING = 3'd4;
  localparam logic [StatusW-1:0] ST_DIED    = 3'd5;

  // classified command word passed from front to back
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [SlotW-1:0]   slot;
    logic               slot_ok;
    logic [InPrioW-1:0] prio;
    logic               coop;
    logic [StatusW-1:0] ns;
    logic               ns_ok;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/dttp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttp_front
// takes input words, checks slot and status range, holds one command
// ----------------------------------------------------------------------------
module dttp_front #(
  parameter int MAX_TASKS = dttp_pkg::MaxTasks
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dttp_pkg::OpW-1:0]      op_i,
  input  wire logic [dttp_pkg::SlotW-1:0]    slot_i,
  input  wire logic [dttp_pkg::InPrioW-1:0]  prio_i,
  input  wire logic                          coop_i,
  input  wire logic [dttp_pkg::StatusW-1:0]  new_status_i,
  output logic                               cmd_valid_o,
  input  wire logic                          cmd_ready_i,
  output dttp_pkg::cmd_t                     cmd_o
);

  logic           hold_valid_q, hold_valid_d;
  dttp_pkg::cmd_t hold_q;
  dttp_pkg::cmd_t cls;
  logic           in_acc;

  assign in_ready_o  = !hold_valid_q || cmd_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cmd_valid_o = hold_valid_q;
  assign cmd_o       = hold_q;

  always_comb begin
    cls.op      = op_i;
    cls.slot    = slot_i;
    cls.slot_ok = (32'(slot_i) < MAX_TASKS);
    cls.prio    = prio_i;
    cls.coop    = coop_i;
    cls.ns      = new_status_i;
    cls.ns_ok   = (new_status_i <= dttp_pkg::ST_DIED);
  end

  always_comb begin
    if (in_acc) begin
      hold_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      hold_valid_d = 1'b0;
    end else begin
      hold_valid_d = hold_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dttp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttp_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module dttp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire dttp_pkg::cmd_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output dttp_pkg::cmd_t      pop_data_o
);

  localparam int Depth = dttp_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dttp_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dttp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dttp_back
// executes commands on the task table and drives the result register
// ----------------------------------------------------------------------------
module dttp_back #(
  parameter int MAX_TASKS = dttp_pkg::MaxTasks,
  parameter int PRIO_BITS = dttp_pkg::PrioBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  output logic                              cmd_ready_o,
  input  wire dttp_pkg::cmd_t               cmd_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              found_o,
  output logic [dttp_pkg::SlotW-1:0]        chosen_o,
  output logic [dttp_pkg::TicksW-1:0]       chosen_ticks_o
);

  localparam int CW   = PRIO_BITS + 1;
  localparam int IdxW = $clog2(MAX_TASKS);
  localparam int CntW = $clog2(MAX_TASKS + 1);
  localparam int StW  = dttp_pkg::StatusW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_OP    = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  // task table
  logic [StW-1:0]       state_mem  [MAX_TASKS];
  logic [CW-1:0]        credit_mem [MAX_TASKS];
  logic [PRIO_BITS-1:0] prio_mem   [MAX_TASKS];
  logic                 coop_mem   [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_q;

  logic [StW-1:0]       st_rd_q;
  logic [CW-1:0]        cr_rd_q;
  logic [PRIO_BITS-1:0] pr_rd_q;
  logic                 cp_rd_q;
  logic                 vld_rd_q;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic                 st_we, cr_we, pr_we;
  logic [IdxW-1:0]      st_wa, cr_wa, pr_wa;
  logic [StW-1:0]       st_wd;
  logic [CW-1:0]        cr_wd;
  logic [PRIO_BITS-1:0] pr_wd;
  logic                 cp_wd;

  // sequencer
  logic [1:0]           fsm_q, fsm_d;
  dttp_pkg::cmd_t       cmd_q, cmd_d;
  logic [CntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [IdxW-1:0]      pidx_q, pidx_d;
  logic                 have_q, have_d;
  logic [IdxW-1:0]      best_q, best_d;
  logic [CW-1:0]        best_cred_q, best_cred_d;

  logic                          res_found_q, res_found_d;
  logic [dttp_pkg::SlotW-1:0]    res_chosen_q, res_chosen_d;
  logic [dttp_pkg::TicksW-1:0]   res_ticks_q, res_ticks_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q;
  logic [dttp_pkg::SlotW-1:0]    out_chosen_q;
  logic [dttp_pkg::TicksW-1:0]   out_ticks_q;
  logic                          out_load;

  // per-step values
  logic [StW-1:0]       eff_st;
  logic                 eff_coop;
  logic                 decay;
  logic [CW-1:0]        new_cr;
  logic                 take;
  logic                 ok;
  logic [CW-1:0]        op_ticks;
  logic [PRIO_BITS-1:0] pm;
  logic [IdxW-1:0]      k;

  assign eff_st   = vld_rd_q ? st_rd_q : dttp_pkg::ST_DIED;
  assign eff_coop = vld_rd_q && cp_rd_q;
  assign pm       = PRIO_BITS'(cmd_q.prio);
  assign k        = IdxW'(cmd_q.slot);

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign chosen_o       = out_chosen_q;
  assign chosen_ticks_o = out_ticks_q;

  always_comb begin
    fsm_d        = fsm_q;
    cmd_d        = cmd_q;
    rd_cnt_d     = rd_cnt_q;
    pidx_d       = pidx_q;
    have_d       = have_q;
    best_d       = best_q;
    best_cred_d  = best_cred_q;
    res_found_d  = res_found_q;
    res_chosen_d = res_chosen_q;
    res_ticks_d  = res_ticks_q;
    cmd_ready_o  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    st_we        = 1'b0;
    st_wa        = k;
    st_wd        = dttp_pkg::ST_READY;
    cr_we        = 1'b0;
    cr_wa        = k;
    cr_wd        = CW'(pm);
    pr_we        = 1'b0;
    pr_wa        = k;
    pr_wd        = pm;
    cp_wd        = cmd_q.coop;
    out_load     = 1'b0;
    ok           = 1'b0;
    op_ticks     = '0;
    // decay and ready compare for the entry in the read register
    decay  = (eff_st != dttp_pkg::ST_DIED) &&
             (eff_st == dttp_pkg::ST_BLOCKED || eff_st == dttp_pkg::ST_WAITING ||
              eff_st == dttp_pkg::ST_HANGING || eff_coop);
    new_cr = decay ? CW'(CW'(cr_rd_q >> 1) + CW'(pr_rd_q)) : cr_rd_q;
    take   = (eff_st == dttp_pkg::ST_READY) && (!have_q || new_cr > best_cred_q);

    unique case (fsm_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          if (cmd_i.op == dttp_pkg::OP_PICK) begin
            rd_en       = 1'b1;
            rd_addr     = '0;
            rd_cnt_d    = CntW'(1);
            pidx_d      = '0;
            have_d      = 1'b0;
            best_d      = '0;
            best_cred_d = '0;
            fsm_d       = S_SWEEP;
          end else if (!cmd_i.slot_ok) begin
            res_found_d  = 1'b0;
            res_chosen_d = cmd_i.slot;
            res_ticks_d  = '0;
            fsm_d        = S_FIN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(cmd_i.slot);
            fsm_d   = S_OP;
          end
        end
      end
      S_OP: begin
        unique case (cmd_q.op)
          dttp_pkg::OP_CREATE: begin
            if (eff_st == dttp_pkg::ST_DIED) begin
              ok       = 1'b1;
              st_we    = 1'b1;
              st_wd    = dttp_pkg::ST_READY;
              cr_we    = 1'b1;
              cr_wd    = CW'(pm);
              pr_we    = 1'b1;
              op_ticks = CW'(pm);
            end
          end
          dttp_pkg::OP_SET: begin
            if (eff_st != dttp_pkg::ST_DIED && cmd_q.ns_ok) begin
              ok       = 1'b1;
              st_we    = 1'b1;
              st_wd    = cmd_q.ns;
              op_ticks = (cmd_q.ns == dttp_pkg::ST_DIED) ? '0 : cr_rd_q;
            end
          end
          dttp_pkg::OP_REQUEUE: begin
            if (eff_st != dttp_pkg::ST_DIED) begin
              ok       = 1'b1;
              st_we    = 1'b1;
              st_wd    = dttp_pkg::ST_READY;
              cr_we    = 1'b1;
              cr_wd    = CW'(pr_rd_q);
              op_ticks = CW'(pr_rd_q);
            end
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        res_found_d  = ok;
        res_chosen_d = cmd_q.slot;
        res_ticks_d  = dttp_pkg::TicksW'(op_ticks);
        fsm_d        = S_FIN;
      end
      S_SWEEP: begin
        // read slot n while slot n-1 is updated and compared
        if (rd_cnt_q != CntW'(MAX_TASKS)) begin
          rd_en    = 1'b1;
          rd_addr  = rd_cnt_q[IdxW-1:0];
          pidx_d   = rd_cnt_q[IdxW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        cr_we = decay;
        cr_wa = pidx_q;
        cr_wd = new_cr;
        if (take) begin
          have_d      = 1'b1;
          best_d      = pidx_q;
          best_cred_d = new_cr;
        end
        if (pidx_q == IdxW'(MAX_TASKS - 1)) begin
          if (have_d) begin
            st_we = 1'b1;
            st_wa = best_d;
            st_wd = dttp_pkg::ST_RUNNING;
          end
          res_found_d  = have_d;
          res_chosen_d = dttp_pkg::SlotW'(best_d);
          res_ticks_d  = dttp_pkg::TicksW'(best_cred_d);
          fsm_d        = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          fsm_d    = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
      if (st_we) begin
        valid_q[st_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rd_cnt_q     <= rd_cnt_d;
    pidx_q       <= pidx_d;
    have_q       <= have_d;
    best_q       <= best_d;
    best_cred_q  <= best_cred_d;
    res_found_q  <= res_found_d;
    res_chosen_q <= res_chosen_d;
    res_ticks_q  <= res_ticks_d;
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_chosen_q <= res_chosen_q;
      out_ticks_q  <= res_ticks_q;
    end
  end

  // table memories, registered read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      st_rd_q  <= state_mem[rd_addr];
      cr_rd_q  <= credit_mem[rd_addr];
      pr_rd_q  <= prio_mem[rd_addr];
      cp_rd_q  <= coop_mem[rd_addr];
      vld_rd_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      state_mem[st_wa] <= st_wd;
    end
    if (cr_we) begin
      credit_mem[cr_wa] <= cr_wd;
    end
    if (pr_we) begin
      prio_mem[pr_wa] <= pr_wd;
      coop_mem[pr_wa] <= cp_wd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/decaying_tick_task_picker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decaying_tick_task_picker_core
// task slot table with credit decay and pick of the best ready task
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one command word: create,
//   set status, requeue after slice, or pick next
//   output channel (out_valid_o / out_ready_i) returns one result word per
//   command: found, chosen slot and its tick credit
// path of a command
//   a word passes a front register and a two-entry queue, then the back
//   sequencer; create, set status and requeue each pass the back end's
//   read, update and result steps, and a pick sweeps every slot, one slot
//   per cycle through the single read port of the task table, before its
//   result step; the result word is then loaded into the output register
//   that drives out_valid_o
// reset
//   all slots read as died (free); no clearing pass, per-slot valid bits
// receiver stall
//   a finished result waits in the output register; the back end holds its
//   next result, the queue and front register keep taking words until full
// ----------------------------------------------------------------------------
module decaying_tick_task_picker_core #(
  parameter int MAX_TASKS = dttp_pkg::MaxTasks,
  parameter int PRIO_BITS = dttp_pkg::PrioBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command words
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dttp_pkg::OpW-1:0]      op_i,
  input  wire logic [dttp_pkg::SlotW-1:0]    slot_i,
  input  wire logic [dttp_pkg::InPrioW-1:0]  prio_i,
  input  wire logic                          coop_i,
  input  wire logic [dttp_pkg::StatusW-1:0]  new_status_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic [dttp_pkg::SlotW-1:0]         chosen_o,
  output logic [dttp_pkg::TicksW-1:0]        chosen_ticks_o
);

  // front to queue
  logic           f_valid, f_ready;
  dttp_pkg::cmd_t f_cmd;
  // queue to back
  logic           q_valid, q_ready;
  dttp_pkg::cmd_t q_cmd;

  // front: range checks on slot and status, one holding register
  dttp_front #(
    .MAX_TASKS (MAX_TASKS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .slot_i       (slot_i),
    .prio_i       (prio_i),
    .coop_i       (coop_i),
    .new_status_i (new_status_i),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd)
  );

  // decoupling queue, lets the front keep taking words during a pick sweep
  dttp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // back: table memories, slot op sequencer and pick sweep
  dttp_back #(
    .MAX_TASKS (MAX_TASKS),
    .PRIO_BITS (PRIO_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .cmd_i          (q_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .chosen_o       (chosen_o),
    .chosen_ticks_o (chosen_ticks_o)
  );

endmodule
`default_nettype wire
